[hdl/pep_pkg.sv]
`default_nettype none

package pep_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 64;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int CHAR_W      = 8;
    localparam int STAT_W      = 3;
    localparam int OUT_W       = 40;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_BADCHAR  = 3'd1;
    localparam logic [STAT_W-1:0] ST_MISSING  = 3'd2;
    localparam logic [STAT_W-1:0] ST_DIVZERO  = 3'd3;
    localparam logic [STAT_W-1:0] ST_NORESULT = 3'd4;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd5;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_RD_A,
        S_OP,
        S_DIV,
        S_WB,
        S_END,
        S_FIN
    } t_state;

    // Stack memory access
    typedef struct packed {
        logic              wr_en;
        logic [PTR_W-1:0]  wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [PTR_W-1:0]  rd_addr;
    } t_ram_req;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

[hdl/pep_stack_ram.sv]
`default_nettype none

module pep_stack_ram (
    input  wire logic                     i_clk,
    input  wire pep_pkg::t_ram_req        i_req,
    output logic [pep_pkg::DATA_W-1:0]    o_rd_data
);

    logic [pep_pkg::DATA_W-1:0] r_mem [pep_pkg::STACK_DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // Registered read port; hold data between reads
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            o_rd_data <= r_mem[i_req.rd_addr];
        end
    end

endmodule

`default_nettype wire

[hdl/pep_divider.sv]
`default_nettype none

module pep_divider (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pep_pkg::t_div_req i_req,
    output pep_pkg::t_div_rsp      o_rsp
);

    localparam int W     = pep_pkg::DATA_W;
    localparam int STEP_W = $clog2(W);

    logic              r_busy;
    logic              r_fin;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [W-1:0]      r_rem;
    logic [W-1:0]      r_q;
    logic [W-1:0]      r_d;
    logic              r_neg;
    logic [W-1:0]      r_quot;

    logic [W:0]        shifted;
    logic [W:0]        diff;

    // One restoring step: shift in the next dividend bit and try the subtract
    assign shifted = {r_rem, r_q[W-1]};
    assign diff    = shifted - {1'b0, r_d};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    // Datapath: take magnitudes, iterate, then restore the sign
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_q   <= i_req.dividend[W-1] ? (W'(0) - i_req.dividend) : i_req.dividend;
            r_d   <= i_req.divisor[W-1]  ? (W'(0) - i_req.divisor)  : i_req.divisor;
            r_neg <= i_req.dividend[W-1] ^ i_req.divisor[W-1];
        end else if (r_busy) begin
            if (!diff[W]) begin
                r_rem <= diff[W-1:0];
                r_q   <= {r_q[W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[W-1:0];
                r_q   <= {r_q[W-2:0], 1'b0};
            end
        end
        if (r_fin) begin
            r_quot <= r_neg ? (W'(0) - r_q) : r_q;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

`default_nettype wire

[hdl/prefix_expression_evaluator.sv]
`default_nettype none

// Prefix expression evaluator. Characters of the expression enter one per
// transaction on the slave stream, rightmost first, with tlast on the leftmost.
// Digits are pushed to a 64-entry stack held in a synchronous RAM; operators
// read the two top entries, combine them and write the result back. A space or
// a digit is handled in the execute state alone, while '/' waits for the
// 32-step restoring divider. The final character then adds the read
// of the top entry, after which one result leaves on the master stream: the
// value, the status (0 ok, 1 bad character, 2 missing operand, 3 divide by
// zero, 4 no result, 5 overflow) and a flag for operands left over. The first
// error is kept, and the value and flag read zero when the status is not ok.

module prefix_expression_evaluator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] char_code
    input  wire logic        i_s_axis_tlast,   // end_of_expr
    // master stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [39:0]      o_m_axis_tdata    // [31:0] value, [34:32] status,
                                               // [35] extra_operands, [39:36] zero
);

    localparam int CNT_W  = pep_pkg::CNT_W;
    localparam int PTR_W  = pep_pkg::PTR_W;
    localparam int DATA_W = pep_pkg::DATA_W;
    localparam int STAT_W = pep_pkg::STAT_W;
    localparam int CHAR_W = pep_pkg::CHAR_W;
    localparam int OUT_W  = pep_pkg::OUT_W;

    pep_pkg::t_state             r_state, n_state;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic [STAT_W-1:0]           r_err, n_err;
    logic                        r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]           r_char, n_char;
    logic                        r_last, n_last;
    logic [DATA_W-1:0]           r_a, n_a;
    logic [DATA_W-1:0]           r_res, n_res;
    logic [OUT_W-1:0]            r_out_data, n_out_data;

    pep_pkg::t_ram_req           ram_req;
    logic [DATA_W-1:0]           ram_rd_data;
    pep_pkg::t_div_req           div_req;
    pep_pkg::t_div_rsp           div_rsp;

    logic [CNT_W-1:0]            cnt_m1;
    logic [CNT_W-1:0]            cnt_m2;
    logic                        is_space;
    logic                        is_digit;
    logic                        is_op;
    logic [2*DATA_W-1:0]         product;
    logic                        fin_ok;
    pep_pkg::t_state             tail_state;

    pep_stack_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (ram_rd_data)
    );

    pep_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Decode the held character
    assign cnt_m1   = r_cnt - CNT_W'(1);
    assign cnt_m2   = r_cnt - CNT_W'(2);
    assign is_space = (r_char == pep_pkg::CH_SPACE);
    assign is_digit = (r_char >= pep_pkg::CH_ZERO) && (r_char <= pep_pkg::CH_NINE);
    assign is_op    = (r_char == pep_pkg::CH_PLUS) || (r_char == pep_pkg::CH_MINUS) ||
                      (r_char == pep_pkg::CH_STAR) || (r_char == pep_pkg::CH_SLASH);
    assign product  = r_a * ram_rd_data;
    assign fin_ok   = (r_err == pep_pkg::ST_OK) && (r_cnt != '0);
    assign tail_state = r_last ? pep_pkg::S_END : pep_pkg::S_IDLE;

    assign o_s_axis_tready = (r_state == pep_pkg::S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Next state and stack access sequencing
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_err       = r_err;
        n_out_valid = r_out_valid;
        n_char      = r_char;
        n_last      = r_last;
        n_a         = r_a;
        n_res       = r_res;
        n_out_data  = r_out_data;

        ram_req          = '0;
        div_req.start    = 1'b0;
        div_req.dividend = r_a;
        div_req.divisor  = ram_rd_data;

        // drop the result once the transaction completes
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            pep_pkg::S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_char  = i_s_axis_tdata;
                    n_last  = i_s_axis_tlast;
                    n_state = pep_pkg::S_EXEC;
                end
            end
            pep_pkg::S_EXEC: begin
                n_state = tail_state;
                if (r_err != pep_pkg::ST_OK || is_space) begin
                    n_state = tail_state;
                end else if (is_digit) begin
                    if (r_cnt >= CNT_W'(pep_pkg::STACK_DEPTH)) begin
                        n_err = pep_pkg::ST_OVERFLOW;
                    end else begin
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = r_cnt[PTR_W-1:0];
                        ram_req.wr_data = DATA_W'(r_char - pep_pkg::CH_ZERO);
                        n_cnt           = r_cnt + CNT_W'(1);
                    end
                end else if (is_op) begin
                    if (r_cnt < CNT_W'(2)) begin
                        n_err = pep_pkg::ST_MISSING;
                    end else begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = cnt_m1[PTR_W-1:0];
                        n_state         = pep_pkg::S_RD_A;
                    end
                end else begin
                    n_err = pep_pkg::ST_BADCHAR;
                end
            end
            pep_pkg::S_RD_A: begin
                // first popped value is here; fetch the second
                n_a             = ram_rd_data;
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = cnt_m2[PTR_W-1:0];
                n_state         = pep_pkg::S_OP;
            end
            pep_pkg::S_OP: begin
                n_state = pep_pkg::S_WB;
                case (r_char)
                    pep_pkg::CH_PLUS:  n_res = r_a + ram_rd_data;
                    pep_pkg::CH_MINUS: n_res = r_a - ram_rd_data;
                    pep_pkg::CH_STAR:  n_res = product[DATA_W-1:0];
                    pep_pkg::CH_SLASH: begin
                        if (ram_rd_data == '0) begin
                            n_err   = pep_pkg::ST_DIVZERO;
                            n_state = tail_state;
                        end else begin
                            div_req.start = 1'b1;
                            n_state       = pep_pkg::S_DIV;
                        end
                    end
                    default: n_state = tail_state;
                endcase
            end
            pep_pkg::S_DIV: begin
                if (div_rsp.done) begin
                    n_res   = div_rsp.quot;
                    n_state = pep_pkg::S_WB;
                end
            end
            pep_pkg::S_WB: begin
                // pop two, push one
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = cnt_m2[PTR_W-1:0];
                ram_req.wr_data = r_res;
                n_cnt           = cnt_m1;
                n_state         = tail_state;
            end
            pep_pkg::S_END: begin
                if (fin_ok) begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = cnt_m1[PTR_W-1:0];
                end
                n_state = pep_pkg::S_FIN;
            end
            pep_pkg::S_FIN: begin
                // hold until the output register is free
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '0;
                    n_out_data[DATA_W-1:0] = fin_ok ? ram_rd_data : '0;
                    if (r_err == pep_pkg::ST_OK && r_cnt == '0) begin
                        n_out_data[DATA_W+STAT_W-1:DATA_W] = pep_pkg::ST_NORESULT;
                    end else begin
                        n_out_data[DATA_W+STAT_W-1:DATA_W] = r_err;
                    end
                    n_out_data[DATA_W+STAT_W] = fin_ok && (r_cnt > CNT_W'(1));
                    n_cnt   = '0;
                    n_err   = pep_pkg::ST_OK;
                    n_state = pep_pkg::S_IDLE;
                end
            end
            default: n_state = pep_pkg::S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pep_pkg::S_IDLE;
            r_cnt       <= '0;
            r_err       <= pep_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_char     <= n_char;
        r_last     <= n_last;
        r_a        <= n_a;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    // Stack count never exceeds the depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(pep_pkg::STACK_DEPTH))
        else $error("stack count beyond depth");

    // The divider is never started with a zero divisor
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> (div_req.divisor != '0))
        else $error("divider started with zero divisor");

    // An error result carries a zero value and no extra-operands flag
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[DATA_W+STAT_W-1:DATA_W] != pep_pkg::ST_OK))
        |-> (o_m_axis_tdata[DATA_W+STAT_W:0] ==
             {1'b0, o_m_axis_tdata[DATA_W+STAT_W-1:DATA_W], {DATA_W{1'b0}}}))
        else $error("error result with non-zero value");

    // A write-back pops exactly one entry
    a_wb_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pep_pkg::S_WB) |=> (r_cnt == $past(cnt_m1)))
        else $error("write-back did not pop one entry");

endmodule

`default_nettype wire
